// File: hw/rtl/fts_pkg.sv
// Shared constants, types and the microcode table of the Fenwick tree sum engine.
`timescale 1ns / 1ps

package fts_pkg;

    localparam int NUM_POSITIONS = 1024;
    localparam int ADDR_W        = $clog2(NUM_POSITIONS);
    localparam int IDX_W         = 11;
    localparam int POS_W         = IDX_W + 1;  // upward walk may step past N
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 2;
    localparam int IN_TDATA_W    = 56;         // 11 + 11 + 32 packed, padded to bytes
    localparam int OUT_TDATA_W   = 32;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(NUM_POSITIONS);

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd2;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE     = 3'd0;
    localparam t_step ST_ADD_RD   = 3'd1;
    localparam t_step ST_ADD_WR   = 3'd2;
    localparam t_step ST_WALK_A   = 3'd3;
    localparam t_step ST_SWAP     = 3'd4;
    localparam t_step ST_WALK_B   = 3'd5;
    localparam t_step ST_EMIT     = 3'd6;
    localparam t_step ST_EMIT_ERR = 3'd7;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_ADD_MORE,
        C_POS_NZ,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [2:0] {
        P_HOLD,
        P_LOAD,
        P_UP,
        P_DOWN,
        P_LO_M1
    } t_pos_op;

    typedef enum logic [1:0] {
        R_NONE,
        R_SUM,
        R_ERR
    } t_res_op;

    typedef struct packed {
        logic    rd_en;
        logic    walk;
        logic    wr_en;
        logic    clr_acc;
        logic    save_first;
        t_pos_op pos_op;
        t_res_op res_op;
        t_cond   cond;
        t_step   tgt_t;
        t_step   tgt_f;
    } t_uop;

    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '{rd_en: 1'b0, walk: 1'b0, wr_en: 1'b0, clr_acc: 1'b0, save_first: 1'b0,
              pos_op: P_HOLD, res_op: R_NONE, cond: C_ALWAYS,
              tgt_t: ST_IDLE, tgt_f: ST_IDLE};
        case (step)
            ST_IDLE: begin
                u.cond    = C_DISPATCH;
                u.pos_op  = P_LOAD;
                u.clr_acc = 1'b1;
            end
            ST_ADD_RD: begin
                u.rd_en = 1'b1;
                u.tgt_t = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                u.wr_en  = 1'b1;
                u.pos_op = P_UP;
                u.cond   = C_ADD_MORE;
                u.tgt_t  = ST_ADD_RD;
                u.tgt_f  = ST_IDLE;
            end
            ST_WALK_A: begin
                u.walk   = 1'b1;
                u.pos_op = P_DOWN;
                u.cond   = C_POS_NZ;
                u.tgt_t  = ST_WALK_A;
                u.tgt_f  = ST_SWAP;
            end
            ST_SWAP: begin
                u.save_first = 1'b1;
                u.clr_acc    = 1'b1;
                u.pos_op     = P_LO_M1;
                u.tgt_t      = ST_WALK_B;
            end
            ST_WALK_B: begin
                u.walk   = 1'b1;
                u.pos_op = P_DOWN;
                u.cond   = C_POS_NZ;
                u.tgt_t  = ST_WALK_B;
                u.tgt_f  = ST_EMIT;
            end
            ST_EMIT: begin
                u.res_op = R_SUM;
                u.cond   = C_OUT_FREE;
                u.tgt_t  = ST_IDLE;
                u.tgt_f  = ST_EMIT;
            end
            ST_EMIT_ERR: begin
                u.res_op = R_ERR;
                u.cond   = C_OUT_FREE;
                u.tgt_t  = ST_IDLE;
                u.tgt_f  = ST_EMIT_ERR;
            end
            default: begin
                u.cond = C_ALWAYS;
            end
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/fts_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module fts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fenwick_tree_sum_engine_core.sv
// Top level of the Fenwick tree sum engine: microcoded sequencer and tree store.
`timescale 1ns / 1ps

// Binary indexed tree of 32-bit wrapping sums over NUM_POSITIONS one-based
// positions, held in one RAM with registered read. Mode 0 adds a value at a
// position (no result beat); mode 1 returns the sum over index..upper_index;
// mode 2 returns the value at index. Bad query indexes give sum 0 with the
// error flag in tuser; adds at a bad index and mode 3 are dropped. After
// reset the store is swept to zero, one word a cycle over all NUM_POSITIONS
// words, with the input held off. A point add reads, then writes, each tree
// node that it touches (through the single RAM port pair); an add at position
// 1 touches 11 nodes. A query walks down the upper prefix, saves its sum,
// walks down the prefix below the lower index and emits the difference;
// each walk does one RAM read per cycle and touches at most 10 nodes, never
// 10 for both. The next beat is accepted as soon as the sequencer is back
// at its idle step, even while a result waits on the output register.
module fenwick_tree_sum_engine_core
    import fts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: index[10:0], upper_index[21:11], value[53:22], zero pad[55:54]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: mode[1:0]
    input  logic [MODE_W-1:0]      i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: sum[31:0]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // tuser: index_error[0]
    output logic                   o_m_tuser
);

    // control
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;
    t_step             r_step, n_step;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_lo;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_first;
    logic [DATA_W-1:0] r_out_sum;
    logic              r_out_err;

    t_uop              uop;
    logic              in_acc;
    logic              out_free;
    logic              pos_nz;
    logic              cond_ok;
    logic [POS_W-1:0]  pos_lb;
    logic [POS_W-1:0]  pos_up;
    logic [ADDR_W-1:0] node_addr;
    t_step             dispatch;

    logic [IDX_W-1:0]  in_lo;
    logic [IDX_W-1:0]  in_hi;
    logic [DATA_W-1:0] in_value;
    logic              lo_ok;
    logic              hi_ok;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;

    assign in_lo    = i_s_tdata[IDX_W-1:0];
    assign in_hi    = i_s_tdata[2*IDX_W-1:IDX_W];
    assign in_value = i_s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

    assign lo_ok = (in_lo != '0) && ({1'b0, in_lo} <= POS_MAX);
    assign hi_ok = (in_hi != '0) && ({1'b0, in_hi} <= POS_MAX);

    assign uop        = uop_rom(r_step);
    assign o_s_tready = (r_step == ST_IDLE) && !r_clr;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign pos_nz    = (r_pos != '0);
    assign pos_lb    = r_pos & (~r_pos + POS_W'(1));
    assign pos_up    = r_pos + pos_lb;
    assign node_addr = ADDR_W'(r_pos - POS_W'(1));

    always_comb begin
        dispatch = ST_IDLE;
        case (i_s_tuser)
            MODE_ADD:   dispatch = lo_ok ? ST_ADD_RD : ST_IDLE;
            MODE_RANGE: dispatch = (lo_ok && hi_ok && (in_lo <= in_hi)) ? ST_WALK_A
                                                                        : ST_EMIT_ERR;
            MODE_POINT: dispatch = lo_ok ? ST_WALK_A : ST_EMIT_ERR;
            default:    dispatch = ST_IDLE;
        endcase
    end

    always_comb begin
        cond_ok = 1'b1;
        case (uop.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_DISPATCH: cond_ok = in_acc;
            C_ADD_MORE: cond_ok = (pos_up <= POS_MAX);
            C_POS_NZ:   cond_ok = pos_nz;
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b1;
        endcase
    end

    always_comb begin
        if (uop.cond == C_DISPATCH) begin
            n_step = cond_ok ? dispatch : uop.tgt_f;
        end else begin
            n_step = cond_ok ? uop.tgt_t : uop.tgt_f;
        end
    end

    always_comb begin
        n_pos = r_pos;
        case (uop.pos_op)
            P_HOLD:  n_pos = r_pos;
            P_LOAD:  begin
                if (in_acc) begin
                    n_pos = {1'b0, (i_s_tuser == MODE_RANGE) ? in_hi : in_lo};
                end
            end
            P_UP:    n_pos = pos_up;
            P_DOWN:  n_pos = pos_nz ? (r_pos - pos_lb) : r_pos;
            P_LO_M1: n_pos = {1'b0, r_lo} - POS_W'(1);
            default: n_pos = r_pos;
        endcase
    end

    // a walk read issued this cycle returns its word next cycle
    assign n_pend = uop.walk && pos_nz;

    always_comb begin
        if (uop.clr_acc) begin
            n_acc = '0;
        end else if (r_pend) begin
            n_acc = r_acc + ram_rdata;
        end else begin
            n_acc = r_acc;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if ((uop.res_op != R_NONE) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    assign ram_re    = !r_clr && (uop.rd_en || (uop.walk && pos_nz));
    assign ram_we    = r_clr || uop.wr_en;
    assign ram_waddr = r_clr ? r_clr_addr : node_addr;
    assign ram_wdata = r_clr ? '0 : (ram_rdata + r_value);

    fts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_POSITIONS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (node_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_step      <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(NUM_POSITIONS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_step      <= n_step;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_acc <= n_acc;
        if (in_acc) begin
            r_lo    <= in_lo;
            r_value <= in_value;
        end
        if (uop.save_first) begin
            r_first <= r_acc;
        end
        if ((uop.res_op != R_NONE) && out_free) begin
            r_out_sum <= (uop.res_op == R_SUM) ? (r_first - r_acc) : '0;
            r_out_err <= (uop.res_op == R_ERR);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sum;
    assign o_m_tuser  = r_out_err;

endmodule

// File: tb/tb.sv
// Testbench for the Fenwick tree sum engine: directed and random beats checked against a tree model.
`timescale 1ns / 1ps

module tb;
    import fts_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 1300;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_BEATS   = 30;
    localparam int TAIL_CYCLES  = 40;   // outlasts the longest add walk
    localparam int MAX_REPORTS  = 10;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        t_word sum;
        logic  index_error;
    } t_result;

    class fenwick_scoreboard;
        t_word   tree_node[NUM_POSITIONS];
        t_result expected_q[$];
        int      mismatches;
        int      adds;
        int      dropped;
        int      queries;
        int      bad_queries;
        int      checked;

        function new();
            foreach (tree_node[i]) tree_node[i] = '0;
            mismatches  = 0;
            adds        = 0;
            dropped     = 0;
            queries     = 0;
            bad_queries = 0;
            checked     = 0;
        endfunction

        function bit position_ok(t_idx p);
            return p >= 1 && p <= NUM_POSITIONS;
        endfunction

        // sum of positions 1..p, stepping down by the lowest set bit
        function t_word walk_down_total(int p);
            t_word acc;
            acc = '0;
            while (p > 0) begin
                acc += tree_node[p-1];
                p -= p & -p;
            end
            return acc;
        endfunction

        function void note_beat(logic [MODE_W-1:0] mode, t_idx idx, t_idx upper, t_word val);
            int      p;
            t_result want;
            want = '0;
            p    = int'(idx);
            case (mode)
                MODE_ADD: begin
                    if (!position_ok(idx)) begin
                        dropped++;
                        return;
                    end
                    adds++;
                    while (p <= NUM_POSITIONS) begin
                        tree_node[p-1] += val;
                        p += p & -p;
                    end
                    return;
                end
                MODE_RANGE: begin
                    want.index_error = !position_ok(idx) || !position_ok(upper) || idx > upper;
                    if (!want.index_error)
                        want.sum = walk_down_total(int'(upper)) - walk_down_total(p - 1);
                end
                MODE_POINT: begin
                    want.index_error = !position_ok(idx);
                    if (!want.index_error)
                        want.sum = walk_down_total(p) - walk_down_total(p - 1);
                end
                default: begin
                    dropped++;
                    return;
                end
            endcase
            queries++;
            if (want.index_error)
                bad_queries++;
            expected_q.push_back(want);
        endfunction

        function void check_beat(t_word sum, logic err);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result beat: sum %h error %b", sum, err);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (sum !== want.sum || err !== want.index_error) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result %0d: sum exp %h got %h, error exp %b got %b",
                             checked, want.sum, sum, want.index_error, err);
            end
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // tdata: index[10:0], upper_index[21:11], value[53:22], zero pad[55:54]
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    // tuser: mode[1:0]
    logic [MODE_W-1:0]      i_s_tuser  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // tdata: sum[31:0]
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // tuser: index_error[0]
    logic                   o_m_tuser;

    fenwick_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;

    fenwick_tree_sum_engine_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

    // result side: check accepted beats, then pick tready for the next edge
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                sb.check_beat(o_m_tdata, o_m_tuser);
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(input logic [MODE_W-1:0] mode, input t_idx idx, input t_idx upper,
                             input t_word val);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, val, upper, idx};
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_beat(mode, idx, upper, val);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_idx random_position();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 2)
            return '0;
        if (pick < 4)
            return t_idx'($urandom_range(2047, NUM_POSITIONS + 1));
        if (pick < 14) begin
            case ($urandom_range(5, 0))
                0: return t_idx'(1);
                1: return t_idx'(2);
                2: return t_idx'(NUM_POSITIONS / 2);
                3: return t_idx'(NUM_POSITIONS / 2 + 1);
                4: return t_idx'(NUM_POSITIONS - 1);
                default: return t_idx'(NUM_POSITIONS);
            endcase
        end
        // a small cluster so that adds pile up on shared tree nodes
        if (pick < 40)
            return t_idx'($urandom_range(16, 1));
        return t_idx'($urandom_range(NUM_POSITIONS, 1));
    endfunction

    task automatic send_random_beat(input bit queries_only);
        logic [MODE_W-1:0] mode;
        t_idx idx;
        t_idx upper;
        t_idx swap;
        int   pick;
        pick  = queries_only ? $urandom_range(93, 45) : $urandom_range(99, 0);
        idx   = random_position();
        upper = random_position();
        if (pick < 45) begin
            mode = MODE_ADD;
        end else if (pick < 72) begin
            mode = MODE_RANGE;
            // mostly well-ordered ranges, some left reversed
            if (idx > upper && $urandom_range(9, 0) != 0) begin
                swap  = idx;
                idx   = upper;
                upper = swap;
            end
        end else if (pick < 94) begin
            mode = MODE_POINT;
        end else begin
            mode = MODE_UNUSED;
        end
        send_beat(mode, idx, upper, $urandom());
    endtask

    initial begin : stimulus
        int tx_phase[4];
        int rx_phase[4];
        tx_phase = '{0, 70, 0, 34};
        rx_phase = '{0, 0, 70, 34};
        sb = new();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, field extremes, ignored adds, every error case
        send_beat(MODE_POINT, 11'd1, 11'd0, 32'hDEAD_BEEF);
        send_beat(MODE_ADD, 11'd1, 11'h7FF, 32'h7FFF_FFFF);
        send_beat(MODE_ADD, 11'd1024, 11'd0, 32'h8000_0000);
        send_beat(MODE_ADD, 11'd0, 11'd0, 32'd5);
        send_beat(MODE_ADD, 11'd1025, 11'd3, 32'd7);
        send_beat(MODE_ADD, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF);
        send_beat(MODE_ADD, 11'd512, 11'd0, 32'hFFFF_FFFF);
        send_beat(MODE_ADD, 11'd1023, 11'd0, 32'd1);
        send_beat(MODE_UNUSED, 11'd5, 11'd9, 32'd99);
        send_beat(MODE_RANGE, 11'd1, 11'd1024, 32'h0);
        send_beat(MODE_RANGE, 11'd1, 11'd1, 32'h0);
        send_beat(MODE_RANGE, 11'd1024, 11'd1024, 32'h0);
        send_beat(MODE_RANGE, 11'd1023, 11'd1024, 32'h0);
        send_beat(MODE_RANGE, 11'd5, 11'd4, 32'h0);
        send_beat(MODE_RANGE, 11'd0, 11'd5, 32'h0);
        send_beat(MODE_RANGE, 11'd5, 11'd0, 32'h0);
        send_beat(MODE_RANGE, 11'd3, 11'd1025, 32'h0);
        send_beat(MODE_RANGE, 11'h7FF, 11'h7FF, 32'h0);
        send_beat(MODE_POINT, 11'd0, 11'd7, 32'h0);
        send_beat(MODE_POINT, 11'd1025, 11'd0, 32'h0);
        send_beat(MODE_POINT, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF);
        send_beat(MODE_POINT, 11'd1024, 11'd0, 32'h0);
        send_beat(MODE_POINT, 11'd512, 11'd0, 32'h0);
        send_beat(MODE_POINT, 11'd1023, 11'd0, 32'h0);
        send_beat(MODE_RANGE, 11'd511, 11'd513, 32'h0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_phase[ph];
            rx_stall_pct = rx_phase[ph];
            repeat (RANDOM_BEATS / 4) send_random_beat(1'b0);
            if (ph == 0) begin
                // long output stall while queries keep coming, so input backs up
                rx_hold_req = 1'b1;
                repeat (HOLD_BEATS) send_random_beat(1'b1);
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run: %0d adds, %0d queries (%0d with bad indexes), %0d dropped beats",
                 sb.adds, sb.queries, sb.bad_queries, sb.dropped);
        $display("Compared %0d results over four idle/stall mixes plus a long output hold, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
